// ----- sv/irdp_pkg.sv -----
// Shared types, constants and coefficient tables for the IR distance block.
package irdp_pkg;

	localparam int CHANNELS   = 6;
	localparam int SHORT_CH   = 4;
	localparam int POLY_TERMS = 8;
	localparam int ADC_W      = 10;
	localparam int DIST_W     = 20;
	localparam int WEIGHT_W   = 17;
	localparam int ACC_W      = 104;
	localparam int QUO_W      = 21;
	localparam int D5_W       = 47;
	localparam int NUM_W      = QUO_W + D5_W;
	localparam int QEST_SH    = 36;
	localparam int RECIP_W    = 24;
	localparam int RECIP_SH   = 34;
	localparam int DEN_EXP    = 20;
	localparam int TERM_W     = $clog2(POLY_TERMS);
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd36045;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [PADDR_W-1:0]  ADDR_WEIGHT  = 3'd0;

	localparam logic signed [DIST_W-1:0] DIST_MAX = 20'sd524287;
	localparam logic signed [DIST_W-1:0] DIST_MIN = -20'sd524288;

	function automatic logic [ACC_W-1:0] pow10(input int n);
		logic [ACC_W-1:0] v;
		v = ACC_W'(1);
		for (int k = 0; k < n; k++) begin
			v = ACC_W'(v * 10);
		end
		return v;
	endfunction

	// Coefficient scaled to the common denominator, times 512 (Q.8 plus a rounding bit).
	function automatic logic signed [ACC_W-1:0] coef_scaled(input int digits, input int exp10);
		logic signed [ACC_W-1:0] v;
		v = ACC_W'(digits);
		for (int k = exp10; k < DEN_EXP; k++) begin
			v = ACC_W'(v * 10);
		end
		v = ACC_W'(v * 512);
		return v;
	endfunction

	localparam logic [ACC_W-1:0] DEN     = pow10(DEN_EXP);
	localparam logic [ACC_W-1:0] OVF_LIM = DEN << QUO_W;

	// Dividing by 10^20 is a shift by 20 followed by a division by 5^20. The quotient
	// estimate from the top 32 numerator bits and this reciprocal is low by at most one.
	localparam logic [D5_W-1:0]    DEN5      = D5_W'(DEN >> DEN_EXP);
	localparam logic [ACC_W-1:0]   RECIP_NUM = ACC_W'(1) << (QEST_SH + RECIP_SH);
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_NUM / ACC_W'(DEN5));

	localparam logic signed [ACC_W-1:0] COEF [2][POLY_TERMS] = '{
		'{coef_scaled(8314, 2), coef_scaled(-9919, 4), coef_scaled(5643, 6),
		  coef_scaled(-1461, 8), coef_scaled(6107, 12), coef_scaled(4797, 14),
		  coef_scaled(-9312, 17), coef_scaled(5219, 20)},
		'{coef_scaled(3023, 1), coef_scaled(-5234, 3), coef_scaled(4667, 5),
		  coef_scaled(-2424, 7), coef_scaled(7581, 10), coef_scaled(-1403, 12),
		  coef_scaled(1412, 15), coef_scaled(-5945, 19)}
	};

	typedef struct packed {
		logic [ADC_W-1:0] adc_front_left;
		logic [ADC_W-1:0] adc_back_left;
		logic [ADC_W-1:0] adc_front_right;
		logic [ADC_W-1:0] adc_back_right;
		logic [ADC_W-1:0] adc_front_center;
		logic [ADC_W-1:0] adc_back_center;
	} sample_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] dist_front_left;
		logic signed [DIST_W-1:0] dist_back_left;
		logic signed [DIST_W-1:0] dist_front_right;
		logic signed [DIST_W-1:0] dist_back_right;
		logic signed [DIST_W-1:0] dist_front_center;
		logic signed [DIST_W-1:0] dist_back_center;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PINIT,
		ST_PSTEP,
		ST_ABS,
		ST_EST,
		ST_MUL,
		ST_FIX,
		ST_SAT,
		ST_FILT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              load_in;
		logic              poly_init;
		logic              poly_step;
		logic              abs_go;
		logic              est_go;
		logic              mul_go;
		logic              fix_go;
		logic              sat_go;
		logic              filt_go;
		logic              push;
		logic [CH_W-1:0]   ch;
		logic [TERM_W-1:0] term;
	} cmd_t;

endpackage

// ----- sv/irdp_ctrl.sv -----
// Sequencer that walks each channel through polynomial, division, saturation and filter steps.
module irdp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_ready,
	output logic            result_valid,
	input  logic            result_ready,
	output irdp_pkg::cmd_t  cmd
);

	localparam logic [irdp_pkg::CH_W-1:0]  CH_LAST  = irdp_pkg::CH_W'(irdp_pkg::CHANNELS - 1);
	localparam logic [irdp_pkg::TERM_W-1:0] TERM_LAST =
		irdp_pkg::TERM_W'(irdp_pkg::POLY_TERMS - 1);
	localparam logic [irdp_pkg::TERM_W-1:0] TERM_FIRST =
		irdp_pkg::TERM_W'(irdp_pkg::POLY_TERMS - 2);

	irdp_pkg::state_t state_q, state_d;
	logic [irdp_pkg::CH_W-1:0]   ch_q;
	logic [irdp_pkg::TERM_W-1:0] term_q;
	logic                        result_valid_q;
	logic                        push;

	assign push = (state_q == irdp_pkg::ST_DONE) && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			irdp_pkg::ST_IDLE: begin
				if (sample_valid) state_d = irdp_pkg::ST_PINIT;
			end
			irdp_pkg::ST_PINIT: state_d = irdp_pkg::ST_PSTEP;
			irdp_pkg::ST_PSTEP: begin
				if (term_q == '0) state_d = irdp_pkg::ST_ABS;
			end
			irdp_pkg::ST_ABS: state_d = irdp_pkg::ST_EST;
			irdp_pkg::ST_EST: state_d = irdp_pkg::ST_MUL;
			irdp_pkg::ST_MUL: state_d = irdp_pkg::ST_FIX;
			irdp_pkg::ST_FIX: state_d = irdp_pkg::ST_SAT;
			irdp_pkg::ST_SAT: state_d = irdp_pkg::ST_FILT;
			irdp_pkg::ST_FILT: begin
				state_d = (ch_q == CH_LAST) ? irdp_pkg::ST_DONE : irdp_pkg::ST_PINIT;
			end
			irdp_pkg::ST_DONE: begin
				if (push) state_d = irdp_pkg::ST_IDLE;
			end
			default: state_d = irdp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.ch = ch_q;
		cmd.term = term_q;
		sample_ready = 1'b0;
		case (state_q)
			irdp_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				cmd.load_in = sample_valid;
			end
			// Horner evaluation starts from the highest coefficient.
			irdp_pkg::ST_PINIT: begin
				cmd.poly_init = 1'b1;
				cmd.term = TERM_LAST;
			end
			irdp_pkg::ST_PSTEP: cmd.poly_step = 1'b1;
			irdp_pkg::ST_ABS:   cmd.abs_go = 1'b1;
			irdp_pkg::ST_EST:   cmd.est_go = 1'b1;
			irdp_pkg::ST_MUL:   cmd.mul_go = 1'b1;
			irdp_pkg::ST_FIX:   cmd.fix_go = 1'b1;
			irdp_pkg::ST_SAT:   cmd.sat_go = 1'b1;
			irdp_pkg::ST_FILT:  cmd.filt_go = 1'b1;
			irdp_pkg::ST_DONE:  cmd.push = push;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irdp_pkg::ST_IDLE;
			ch_q <= '0;
			term_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				irdp_pkg::ST_IDLE:  ch_q <= '0;
				irdp_pkg::ST_PINIT: term_q <= TERM_FIRST;
				irdp_pkg::ST_PSTEP: term_q <= term_q - 1'b1;
				irdp_pkg::ST_FILT: begin
					if (ch_q != CH_LAST) ch_q <= ch_q + 1'b1;
				end
				default: ;
			endcase
			if (push) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/irdp_datapath.sv -----
// Polynomial accumulator, reciprocal divider, saturation and moving-average registers.
module irdp_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  irdp_pkg::cmd_t                  cmd,
	input  irdp_pkg::sample_t               sample,
	input  logic [irdp_pkg::WEIGHT_W-1:0]   weight,
	output irdp_pkg::result_t               result
);

	localparam int DW = irdp_pkg::DIST_W;
	localparam int PW = DW + 1 + irdp_pkg::WEIGHT_W + 1;
	localparam int TOP_W = irdp_pkg::NUM_W - irdp_pkg::QEST_SH;
	localparam int EW = TOP_W + irdp_pkg::RECIP_W;

	irdp_pkg::sample_t in_q;
	irdp_pkg::result_t out_q;
	logic signed [irdp_pkg::ACC_W-1:0] acc_q;
	logic [irdp_pkg::NUM_W-1:0]        num_q;
	logic [irdp_pkg::NUM_W-1:0]        prod_q;
	logic [irdp_pkg::QUO_W-1:0]        quo_q;
	logic                              neg_q;
	logic                              ovf_q;
	logic signed [DW-1:0]              raw_q;
	logic signed [DW-1:0]              filt_q [irdp_pkg::CHANNELS];
	logic                              primed_q;

	logic [irdp_pkg::ADC_W-1:0]        adc [irdp_pkg::CHANNELS];
	logic [irdp_pkg::ADC_W-1:0]        x;
	logic                              set_sel;
	logic signed [irdp_pkg::ACC_W-1:0] coef;
	logic signed [irdp_pkg::ACC_W-1:0] acc_next;
	logic [irdp_pkg::ACC_W-1:0]        mag;
	logic [EW-1:0]                     est;
	logic [irdp_pkg::NUM_W-1:0]        rem;
	logic [irdp_pkg::QUO_W-1:0]        v;
	logic signed [DW-1:0]              raw_d;
	logic [irdp_pkg::WEIGHT_W-1:0]     w_eff;
	logic signed [DW-1:0]              base;
	logic signed [DW:0]                diff;
	logic signed [PW-1:0]              prod;
	logic signed [PW-1:0]              rnd;
	logic signed [DW-1:0]              filt_new;

	assign adc[0] = in_q.adc_front_left;
	assign adc[1] = in_q.adc_back_left;
	assign adc[2] = in_q.adc_front_right;
	assign adc[3] = in_q.adc_back_right;
	assign adc[4] = in_q.adc_front_center;
	assign adc[5] = in_q.adc_back_center;

	assign x = adc[cmd.ch];
	assign set_sel = (cmd.ch >= irdp_pkg::CH_W'(irdp_pkg::SHORT_CH));
	assign coef = irdp_pkg::COEF[set_sel][cmd.term];

	// Horner step: the partial sum stays bounded by the full polynomial, so 104 bits hold it.
	assign acc_next = irdp_pkg::ACC_W'(acc_q * $signed({1'b0, x})) + coef;

	assign mag = acc_q[irdp_pkg::ACC_W-1] ? $unsigned(irdp_pkg::ACC_W'(-acc_q))
	                                      : $unsigned(acc_q);

	// Quotient estimate from the top numerator bits; the remainder check adds the missing one.
	assign est = num_q[irdp_pkg::NUM_W-1 -: TOP_W] * irdp_pkg::RECIP;
	assign rem = num_q - prod_q;

	// The quotient carries one extra bit; halving it with carry rounds halves away from zero.
	assign v = irdp_pkg::QUO_W'(quo_q >> 1) + irdp_pkg::QUO_W'(quo_q[0]);

	always_comb begin
		if (neg_q) begin
			if (ovf_q || v > irdp_pkg::QUO_W'(524288)) raw_d = irdp_pkg::DIST_MIN;
			else raw_d = DW'(~v + 1'b1);
		end else begin
			if (ovf_q || v > irdp_pkg::QUO_W'(524287)) raw_d = irdp_pkg::DIST_MAX;
			else raw_d = DW'(v);
		end
	end

	// F + round((r - F) * w / 2^16) equals the two-product form exactly.
	assign w_eff = (weight > irdp_pkg::WEIGHT_ONE) ? irdp_pkg::WEIGHT_ONE : weight;
	assign base = primed_q ? filt_q[cmd.ch] : raw_q;
	assign diff = {raw_q[DW-1], raw_q} - {base[DW-1], base};
	assign prod = diff * $signed({1'b0, w_eff});
	assign rnd = (prod + PW'(32768)) >>> 16;
	assign filt_new = base + rnd[DW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= sample;
		if (cmd.poly_init) acc_q <= coef;
		else if (cmd.poly_step) acc_q <= acc_next;
		if (cmd.abs_go) begin
			neg_q <= acc_q[irdp_pkg::ACC_W-1];
			ovf_q <= (mag >= irdp_pkg::OVF_LIM);
			num_q <= mag[irdp_pkg::DEN_EXP +: irdp_pkg::NUM_W];
		end
		if (cmd.est_go) begin
			quo_q <= irdp_pkg::QUO_W'(est >> irdp_pkg::RECIP_SH);
		end else if (cmd.fix_go) begin
			quo_q <= quo_q + irdp_pkg::QUO_W'(rem >= irdp_pkg::NUM_W'(irdp_pkg::DEN5));
		end
		if (cmd.mul_go) begin
			prod_q <= irdp_pkg::NUM_W'(quo_q) * irdp_pkg::NUM_W'(irdp_pkg::DEN5);
		end
		if (cmd.sat_go) raw_q <= raw_d;
		if (cmd.push) begin
			out_q.dist_front_left   <= filt_q[0];
			out_q.dist_back_left    <= filt_q[1];
			out_q.dist_front_right  <= filt_q[2];
			out_q.dist_back_right   <= filt_q[3];
			out_q.dist_front_center <= filt_q[4];
			out_q.dist_back_center  <= filt_q[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			for (int c = 0; c < irdp_pkg::CHANNELS; c++) begin
				filt_q[c] <= '0;
			end
		end else begin
			if (cmd.filt_go) filt_q[cmd.ch] <= filt_new;
			if (cmd.push) primed_q <= 1'b1;
		end
	end

	assign result = out_q;

endmodule

// ----- sv/ir_distance_poly_ewma.sv -----
// Top level of the IR distance linearizer with moving-average smoothing.
// Usage:
// A word on the sample channel carries six raw 10-bit ADC readings. Each reading is
// converted to a distance by a 7th-order polynomial (short-range set for the first
// four channels, long-range set for the last two), rounded to signed Q12.8 and
// saturated, then smoothed by a moving average whose weight is the APB register at
// byte address 0 (Q1.16, reset 0.55). The first word after reset loads the raw
// distances directly. The result word holds the six filtered distances.
// Sequence: one word is processed at a time. Each channel passes in turn through the
// shared datapath (coefficient load, 7 Horner steps on the 104-bit accumulator,
// magnitude, reciprocal estimate, back-multiply, correction, saturation and filter
// step); a new word is taken only once the last result is in the output register.
// The finished result sits in an output register, so sample_ready rises again
// while the result still waits for result_ready; a stalled receiver holds the
// block only once the next word's result is ready too.
// Reset clears the filter state and the primed flag and sets the weight to 0.55.
module ir_distance_poly_ewma (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  irdp_pkg::sample_t                sample,
	output logic                             result_valid,
	input  logic                             result_ready,
	output irdp_pkg::result_t                result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [irdp_pkg::PADDR_W-1:0]     paddr,
	input  logic [irdp_pkg::PDATA_W-1:0]     pwdata,
	output logic [irdp_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	irdp_pkg::cmd_t                cmd;
	logic [irdp_pkg::WEIGHT_W-1:0] weight_q;
	logic                          wr_weight;

	assign pready = 1'b1;
	assign wr_weight = psel && penable && pwrite && (paddr == irdp_pkg::ADDR_WEIGHT);
	assign prdata = (paddr == irdp_pkg::ADDR_WEIGHT) ?
		irdp_pkg::PDATA_W'(weight_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= irdp_pkg::WEIGHT_RESET;
		end else if (wr_weight) begin
			weight_q <= pwdata[irdp_pkg::WEIGHT_W-1:0];
		end
	end

	irdp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	irdp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.weight (weight_q),
		.result (result)
	);

	// Once a word is taken, the sequencer is busy on it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample_ready stayed high after a word was accepted");

	// A weight write lands in the register.
	a_weight_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_weight |=> weight_q == $past(pwdata[irdp_pkg::WEIGHT_W-1:0]))
		else $error("weight register did not take the written value");

	// A new result is only launched from the end of processing, never while idle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!sample_ready))
		else $error("result_valid rose without a word in process");

endmodule
